### hw/rtl/qfrm_pkg.sv
// ----------------------------------------------------------------------------
// qfrm_pkg
// Shared types and constants for the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
package qfrm_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int RAD_W         = 32;
    localparam int TERM_W        = 18;
    localparam int QDEPTH        = 4;
    localparam int QUO_W         = 16;

    typedef enum logic [1:0] {
        LEAD_W = 2'd0,
        LEAD_X = 2'd1,
        LEAD_Y = 2'd2,
        LEAD_Z = 2'd3
    } lead_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } item_t;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic               bad_input;
    } result_t;

    typedef struct packed {
        logic                          bad;
        lead_t                         lead;
        logic signed [RAD_W-1:0]       rad;
        logic [3:0][TERM_W-1:0]        d;
    } cls_t;

    typedef struct packed {
        logic  bad;
        lead_t lead;
    } tag_t;

endpackage

### hw/rtl/qfrm_front.sv
// ----------------------------------------------------------------------------
// qfrm_front
// Classifies a matrix: picks the branch, forms radicand and element terms.
// ----------------------------------------------------------------------------
module qfrm_front #(
    parameter int FRAC_BITS = qfrm_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  qfrm_pkg::item_t     item,
    output logic                cls_valid,
    input  logic                cls_taken,
    output qfrm_pkg::cls_t      cls
);

    localparam int RW = qfrm_pkg::RAD_W;
    localparam int TW = qfrm_pkg::TERM_W;

    logic                  valid_reg;
    qfrm_pkg::cls_t        cls_reg;
    qfrm_pkg::cls_t        cls_next;
    logic signed [RW-1:0]  one_s;
    logic signed [TW-1:0]  e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [TW-1:0]  tr;

    assign one_s = RW'(1) << FRAC_BITS;
    assign e00 = TW'(item.m00);
    assign e01 = TW'(item.m01);
    assign e02 = TW'(item.m02);
    assign e10 = TW'(item.m10);
    assign e11 = TW'(item.m11);
    assign e12 = TW'(item.m12);
    assign e20 = TW'(item.m20);
    assign e21 = TW'(item.m21);
    assign e22 = TW'(item.m22);
    assign tr  = e00 + e11 + e22;

    always_comb
    begin
        cls_next = '0;
        if (tr > 0)
        begin
            cls_next.lead = qfrm_pkg::LEAD_W;
            cls_next.rad  = one_s + RW'(tr);
            cls_next.d[1] = e21 - e12;
            cls_next.d[2] = e02 - e20;
            cls_next.d[3] = e10 - e01;
        end
        else if (e00 > e11 && e00 > e22)
        begin
            cls_next.lead = qfrm_pkg::LEAD_X;
            cls_next.rad  = one_s + RW'(e00 - e11 - e22);
            cls_next.d[0] = e21 - e12;
            cls_next.d[2] = e01 + e10;
            cls_next.d[3] = e02 + e20;
        end
        else if (e11 > e22)
        begin
            cls_next.lead = qfrm_pkg::LEAD_Y;
            cls_next.rad  = one_s + RW'(e11 - e00 - e22);
            cls_next.d[0] = e02 - e20;
            cls_next.d[1] = e01 + e10;
            cls_next.d[3] = e12 + e21;
        end
        else
        begin
            cls_next.lead = qfrm_pkg::LEAD_Z;
            cls_next.rad  = one_s + RW'(e22 - e00 - e11);
            cls_next.d[0] = e10 - e01;
            cls_next.d[1] = e02 + e20;
            cls_next.d[2] = e12 + e21;
        end
        cls_next.bad = (cls_next.rad <= 0);
    end

    assign item_stall = valid_reg && !cls_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

### hw/rtl/qfrm_queue.sv
// ----------------------------------------------------------------------------
// qfrm_queue
// Short queue that decouples classification from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qfrm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ok,
    input  qfrm_pkg::cls_t    push_data,
    output logic              pop_valid,
    input  logic              pop,
    output qfrm_pkg::cls_t    pop_data
);

    localparam int D  = qfrm_pkg::QDEPTH;
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    qfrm_pkg::cls_t mem [D];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push, do_pop;

    assign pop_valid = (cnt_reg != '0);
    assign do_pop    = pop && pop_valid;
    assign push_ok   = (cnt_reg != CW'(D)) || do_pop;
    assign do_push   = push_valid && push_ok;
    assign pop_data  = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(D - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(D - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(D))
        else $error("queue count beyond depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

### hw/rtl/qfrm_back.sv
// ----------------------------------------------------------------------------
// qfrm_back
// Pipelined square root and dividers; forms and saturates the quaternion.
// ----------------------------------------------------------------------------
module qfrm_back #(
    parameter int FRAC_BITS = qfrm_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cls_valid,
    output logic               cls_pop,
    input  qfrm_pkg::cls_t     cls,
    output logic               result_valid,
    input  logic               result_stall,
    output qfrm_pkg::result_t  result
);

    localparam int NW = 2 * FRAC_BITS + 20;
    localparam int SQ = FRAC_BITS + 10;
    localparam int RM = SQ + 2;
    localparam int TW = qfrm_pkg::TERM_W;
    localparam int MW = TW - 1;
    localparam int DV = qfrm_pkg::QUO_W;
    localparam int DW = FRAC_BITS + 28;

    logic adv;

    logic                 sv_reg   [SQ+1];
    logic [NW-1:0]        sn_reg   [SQ+1];
    logic [RM-1:0]        srem_reg [SQ+1];
    logic [SQ-1:0]        sroot_reg[SQ+1];
    qfrm_pkg::tag_t       stag_reg [SQ+1];
    logic [3:0][TW-1:0]   sd_reg   [SQ+1];

    logic                 dv_reg   [DV+1];
    logic [SQ-1:0]        ds_reg   [DV+1];
    qfrm_pkg::tag_t       dtag_reg [DV+1];
    logic [3:0][DW-1:0]   drem_reg [DV+1];
    logic [3:0][DV-1:0]   dq_reg   [DV+1];
    logic [3:0]           dneg_reg [DV+1];
    logic [3:0]           dovf_reg [DV+1];

    logic                 out_v_reg;
    qfrm_pkg::result_t    out_reg;
    qfrm_pkg::result_t    out_next;

    assign adv     = !(out_v_reg && result_stall);
    assign cls_pop = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQ; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            for (int j = 0; j <= DV; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= cls_valid;
            for (int i = 0; i < SQ; i++)
            begin
                sv_reg[i+1] <= sv_reg[i];
            end
            dv_reg[0] <= sv_reg[SQ];
            for (int j = 0; j < DV; j++)
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
            out_v_reg <= dv_reg[DV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn_reg[0]    <= NW'($unsigned(cls.rad)) << FRAC_BITS;
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            stag_reg[0]  <= '{bad: cls.bad, lead: cls.lead};
            sd_reg[0]    <= cls.d;
        end
    end

    genvar g;
    generate
        for (g = 0; g < SQ; g++)
        begin : g_sqrt
            logic [RM+1:0] a, b;
            assign a = {srem_reg[g], sn_reg[g][NW-1:NW-2]};
            assign b = {2'b00, sroot_reg[g], 2'b01};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sn_reg[g+1]   <= sn_reg[g] << 2;
                    stag_reg[g+1] <= stag_reg[g];
                    sd_reg[g+1]   <= sd_reg[g];
                    if (a >= b)
                    begin
                        srem_reg[g+1]  <= RM'(a - b);
                        sroot_reg[g+1] <= {sroot_reg[g][SQ-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg[g+1]  <= a[RM-1:0];
                        sroot_reg[g+1] <= {sroot_reg[g][SQ-2:0], 1'b0};
                    end
                end
            end
        end

        for (g = 0; g < 4; g++)
        begin : g_init
            logic signed [TW-1:0] dt;
            logic [MW-1:0]        mag;
            logic [DW-1:0]        num, den;
            assign dt  = $signed(sd_reg[SQ][g]);
            assign mag = dt[TW-1] ? MW'(-dt) : MW'(dt);
            assign num = (DW'(mag) << FRAC_BITS) + DW'(sroot_reg[SQ]);
            assign den = DW'(sroot_reg[SQ]) << 1;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    drem_reg[0][g] <= num;
                    dq_reg[0][g]   <= '0;
                    dneg_reg[0][g] <= dt[TW-1];
                    dovf_reg[0][g] <= (num >= (den << DV));
                end
            end
        end

        for (g = 0; g < DV; g++)
        begin : g_div
            localparam int B = DV - 1 - g;
            logic [DW-1:0] dsh;
            assign dsh = (DW'(ds_reg[g]) << 1) << B;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ds_reg[g+1]   <= ds_reg[g];
                    dtag_reg[g+1] <= dtag_reg[g];
                    dneg_reg[g+1] <= dneg_reg[g];
                    dovf_reg[g+1] <= dovf_reg[g];
                    for (int l = 0; l < 4; l++)
                    begin
                        if (drem_reg[g][l] >= dsh)
                        begin
                            drem_reg[g+1][l]  <= drem_reg[g][l] - dsh;
                            dq_reg[g+1][l]    <= dq_reg[g][l] | (DV'(1) << B);
                        end
                        else
                        begin
                            drem_reg[g+1][l]  <= drem_reg[g][l];
                            dq_reg[g+1][l]    <= dq_reg[g][l];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0]   <= sroot_reg[SQ];
            dtag_reg[0] <= stag_reg[SQ];
        end
    end

    logic [SQ:0]        half;
    logic [3:0][15:0]   comp;

    assign half = (SQ+1)'(ds_reg[DV]) + 1'b1;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (l == int'(dtag_reg[DV].lead))
            begin
                comp[l] = (half[SQ:1] > SQ'(32767)) ? 16'h7fff : 16'(half[SQ:1]);
            end
            else if (dneg_reg[DV][l])
            begin
                comp[l] = (dovf_reg[DV][l] || dq_reg[DV][l] > DV'(32768))
                        ? 16'h8000 : 16'(-dq_reg[DV][l]);
            end
            else
            begin
                comp[l] = (dovf_reg[DV][l] || dq_reg[DV][l] > DV'(32767))
                        ? 16'h7fff : dq_reg[DV][l];
            end
        end
        out_next.bad_input = dtag_reg[DV].bad;
        out_next.qw = dtag_reg[DV].bad ? '0 : $signed(comp[0]);
        out_next.qx = dtag_reg[DV].bad ? '0 : $signed(comp[1]);
        out_next.qy = dtag_reg[DV].bad ? '0 : $signed(comp[2]);
        out_next.qz = dtag_reg[DV].bad ? '0 : $signed(comp[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.bad_input) |->
        (result.qw == 0 && result.qx == 0 && result.qy == 0 && result.qz == 0))
        else $error("flagged result carries nonzero components");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(dv_reg[DV]) && $stable(sv_reg[SQ])))
        else $error("pipeline moved while output held");

endmodule

### hw/rtl/quaternion_from_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix
// Registered path: front classifier, queue, the one-bit-per-stage square root,
// the 16-stage dividers and the output register.
// Throughput: one matrix per cycle while result_stall does not hold the output.
// Reset: asynchronous, clears all valid state; queue empties.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix #(
    parameter int FRAC_BITS = qfrm_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  qfrm_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output qfrm_pkg::result_t  result
);

    logic            f_valid, f_taken;
    qfrm_pkg::cls_t  f_cls;
    logic            q_valid, q_pop;
    qfrm_pkg::cls_t  q_cls;

    qfrm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cls_valid  (f_valid),
        .cls_taken  (f_taken),
        .cls        (f_cls)
    );

    qfrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ok    (f_taken),
        .push_data  (f_cls),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_cls)
    );

    qfrm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cls_valid    (q_valid),
        .cls_pop      (q_pop),
        .cls          (q_cls),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
